// ===== design/lenu_pkg.sv =====
// Shared types and constants for the line ending normalizer.
// No dependencies; imported by every module of the block.
package lenu_pkg;

   localparam logic [7:0]  CHAR_NUL  = 8'h00;
   localparam logic [7:0]  CHAR_LF   = 8'h0A;
   localparam logic [7:0]  CHAR_CR   = 8'h0D;
   localparam logic [7:0]  CHAR_BSL  = 8'h5C;
   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   localparam logic CSR_ESCAPE_MODE        = 1'b0;
   localparam logic CSR_LONE_CR_IS_NEWLINE = 1'b1;

   typedef enum logic [1:0] {
      OP_EMIT,
      OP_ERR,
      OP_BUMP
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  data;
   } op_type;

   typedef struct packed {
      op_type first;
      op_type second;
      logic   has_second;
   } entry_type;

   typedef struct packed {
      logic escape_mode;
      logic lone_cr_is_newline;
   } cfg_type;

endpackage

// ===== design/line_ending_normalizer_unit.sv =====
// Line ending normalizer, top level: configuration registers, front end,
// entry queue and back end. Uses lenu_pkg, lenu_front, lenu_fifo, lenu_back.
//
// Takes one text byte per cycle while req_stall is low and returns normalized
// bytes tagged with line number and output offset. The front end classifies
// each beat in the cycle it is accepted; the back end issues one result per
// cycle while rsp_stall is low, so a beat that yields two results (a held CR
// or backslash resolved by an ordinary byte) holds the back end longer, and the
// QUEUE_DEPTH-entry queue absorbs that. Results pass the queue and the output
// register. After a NUL the block accepts and discards every beat until reset.
module line_ending_normalizer_unit import lenu_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic [31:0] rsp_line_index,
   output logic [31:0] rsp_byte_offset,
   output logic        rsp_illegal_nul,
   output logic        rsp_last_of_run,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic        csr_write_data
);

   cfg_type   cfg_ff, cfg_in;
   logic      push_valid, queue_full, head_valid, pop;
   entry_type push_entry, head_entry;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ESCAPE_MODE:        cfg_in.escape_mode        = csr_write_data;
            CSR_LONE_CR_IS_NEWLINE: cfg_in.lone_cr_is_newline = csr_write_data;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lenu_front u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_stream (req_end_of_stream),
      .queue_full        (queue_full),
      .push_valid        (push_valid),
      .push_entry        (push_entry)
   );

   lenu_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   lenu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_entry      (head_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_line_index  (rsp_line_index),
      .rsp_byte_offset (rsp_byte_offset),
      .rsp_illegal_nul (rsp_illegal_nul),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ===== design/lenu_front.sv =====
// Front end: accepts raw bytes, tracks the held CR or backslash and the halt
// flag, and turns each beat into at most one queue entry of up to two ops. Uses lenu_pkg.
module lenu_front import lenu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_stream,
   input  logic        queue_full,
   output logic        push_valid,
   output entry_type   push_entry
);

   typedef enum logic [1:0] {
      PEND_NONE,
      PEND_CR,
      PEND_BSL
   } pend_type;

   pend_type   pending_ff, pending_in;
   logic       halted_ff, halted_in;
   logic       accept;
   logic [7:0] lone_cr_byte;
   op_type     pre_op, fresh_op;
   logic       pre_valid, use_fresh, fresh_has, fresh_halt;
   pend_type   fresh_pend;

   assign req_stall    = queue_full;
   assign accept       = req_valid && !queue_full;
   assign lone_cr_byte = cfg.lone_cr_is_newline ? CHAR_LF : CHAR_CR;

   always_comb begin
      fresh_op   = '{kind: OP_EMIT, data: req_in_byte};
      fresh_has  = 1'b0;
      fresh_pend = PEND_NONE;
      fresh_halt = 1'b0;
      priority if (req_in_byte == CHAR_CR) begin
         fresh_pend = PEND_CR;
      end else if (req_in_byte == CHAR_BSL && cfg.escape_mode) begin
         fresh_pend = PEND_BSL;
      end else if (req_in_byte == CHAR_NUL) begin
         fresh_op   = '{kind: OP_ERR, data: CHAR_NUL};
         fresh_has  = 1'b1;
         fresh_halt = 1'b1;
      end else begin
         fresh_has = 1'b1;
      end
   end

   always_comb begin
      pre_op    = '{kind: OP_EMIT, data: lone_cr_byte};
      pre_valid = 1'b0;
      use_fresh = 1'b0;
      unique case (pending_ff)
         PEND_CR: begin
            pre_valid = 1'b1;
            if (!req_end_of_stream) begin
               if (req_in_byte == CHAR_LF) begin
                  pre_op = '{kind: OP_EMIT, data: CHAR_LF};
               end else begin
                  use_fresh = 1'b1;
               end
            end
         end
         PEND_BSL: begin
            pre_valid = 1'b1;
            pre_op    = '{kind: OP_EMIT, data: CHAR_BSL};
            if (!req_end_of_stream) begin
               if (req_in_byte == CHAR_LF) begin
                  pre_op = '{kind: OP_BUMP, data: CHAR_LF};
               end else begin
                  use_fresh = 1'b1;
               end
            end
         end
         default: begin
            use_fresh = !req_end_of_stream;
         end
      endcase
   end

   always_comb begin
      pending_in = use_fresh ? fresh_pend : PEND_NONE;
      halted_in  = halted_ff || (use_fresh && fresh_halt);
      if (pre_valid) begin
         push_entry.first      = pre_op;
         push_entry.second     = fresh_op;
         push_entry.has_second = use_fresh && fresh_has;
      end else begin
         push_entry.first      = fresh_op;
         push_entry.second     = fresh_op;
         push_entry.has_second = 1'b0;
      end
      push_valid = accept && !halted_ff && (pre_valid || (use_fresh && fresh_has));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= PEND_NONE;
         halted_ff  <= 1'b0;
      end else if (accept && !halted_ff) begin
         pending_ff <= pending_in;
         halted_ff  <= halted_in;
      end
   end

endmodule

// ===== design/lenu_fifo.sv =====
// Short queue of classified entries between front and back end.
// Uses lenu_pkg for the entry type.
module lenu_fifo import lenu_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head_entry
);

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);

   entry_type              mem_ff [DEPTH];
   logic [PtrWidth-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]    count_ff, count_in;
   logic                   do_push, do_pop;

   assign full       = (count_ff == CntWidth'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== design/lenu_back.sv =====
// Back end: walks the ops of each queue entry, keeps the saturating line and
// byte counters, and drives the registered result beat. Uses lenu_pkg.
module lenu_back import lenu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  entry_type   head_entry,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic [31:0] rsp_line_index,
   output logic [31:0] rsp_byte_offset,
   output logic        rsp_illegal_nul,
   output logic        rsp_last_of_run
);

   logic        idx_ff, idx_in;
   logic [31:0] line_ff, line_in, emitted_ff, emitted_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic [31:0] line_out_ff, line_out_in, offset_ff, offset_in;
   logic        nul_ff, nul_in, last_ff, last_in;
   op_type      cur_op;
   logic        is_last, out_free, fire;

   assign cur_op   = idx_ff ? head_entry.second : head_entry.first;
   assign is_last  = idx_ff || !head_entry.has_second;
   assign out_free = !valid_ff || !rsp_stall;
   assign fire     = head_valid && (cur_op.kind == OP_BUMP || out_free);
   assign pop      = fire && is_last;

   always_comb begin
      idx_in      = idx_ff;
      line_in     = line_ff;
      emitted_in  = emitted_ff;
      valid_in    = valid_ff && rsp_stall;
      byte_in     = byte_ff;
      line_out_in = line_out_ff;
      offset_in   = offset_ff;
      nul_in      = nul_ff;
      last_in     = last_ff;
      if (fire) begin
         idx_in = !is_last;
         unique case (cur_op.kind)
            OP_BUMP: begin
               if (line_ff != COUNT_MAX) line_in = line_ff + 32'd1;
            end
            OP_ERR: begin
               valid_in    = 1'b1;
               byte_in     = CHAR_NUL;
               line_out_in = line_ff;
               offset_in   = emitted_ff;
               nul_in      = 1'b1;
               last_in     = is_last;
            end
            default: begin
               valid_in    = 1'b1;
               byte_in     = cur_op.data;
               line_out_in = line_ff;
               offset_in   = emitted_ff;
               nul_in      = 1'b0;
               last_in     = is_last;
               if (emitted_ff != COUNT_MAX) emitted_in = emitted_ff + 32'd1;
               if (cur_op.data == CHAR_LF && line_ff != COUNT_MAX) begin
                  line_in = line_ff + 32'd1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= 1'b0;
         line_ff    <= 32'd1;
         emitted_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         idx_ff     <= idx_in;
         line_ff    <= line_in;
         emitted_ff <= emitted_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      line_out_ff <= line_out_in;
      offset_ff   <= offset_in;
      nul_ff      <= nul_in;
      last_ff     <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_line_index  = line_out_ff;
   assign rsp_byte_offset = offset_ff;
   assign rsp_illegal_nul = nul_ff;
   assign rsp_last_of_run = last_ff;

endmodule
